// ===== rtl/core/pdf_pkg.sv =====
// pdf_pkg: shared types, field widths and codes for the persist directory fold unit
// used by every module under rtl/core, depends on nothing
package pdf_pkg;

  localparam int ID_W     = 20;
  localparam int WORD_W   = 32;
  localparam int OFFS_W   = 26;
  localparam int SLOT_W   = 21;
  localparam int CNT_W    = 12;
  localparam int LEN_W    = 27;
  localparam int ENTRY_W  = OFFS_W + 1;
  localparam int HEADER_BYTES = 8;
  localparam int DEF_TABLE_ENTRIES = 4096;
  localparam int Q_DEPTH  = 4;

  // input commands
  localparam logic [1:0] CMD_WORD   = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  // result status codes
  localparam logic [3:0] STAT_HEADER   = 4'd0;
  localparam logic [3:0] STAT_STORED   = 4'd1;
  localparam logic [3:0] STAT_RANGE    = 4'd2;
  localparam logic [3:0] STAT_SET      = 4'd3;
  localparam logic [3:0] STAT_BAD_OFFS = 4'd4;
  localparam logic [3:0] STAT_IGNORED  = 4'd5;
  localparam logic [3:0] STAT_HIT      = 4'd6;
  localparam logic [3:0] STAT_MISS     = 4'd7;
  localparam logic [3:0] STAT_CLEARED  = 4'd8;

  // operations handed from front to back
  localparam logic [1:0] OP_RESULT = 2'd0;
  localparam logic [1:0] OP_STORE  = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [WORD_W-1:0] dir_word;
    logic              last_word;
    logic [ID_W-1:0]   query_id;
  } in_item_t;

  typedef struct packed {
    logic [3:0]        status;
    logic              found;
    logic [OFFS_W-1:0] offset_out;
  } out_item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [3:0]        status;
    logic [ID_W-1:0]   slot;
    logic [WORD_W-1:0] word;
  } op_t;

endpackage

// ===== rtl/core/pdf_front.sv =====
// pdf_front: accepts items, runs the directory parser and turns each item into an op
// depends on pdf_pkg
module pdf_front #(
  parameter int TABLE_ENTRIES = pdf_pkg::DEF_TABLE_ENTRIES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  pdf_pkg::in_item_t in_item,
  input  logic              q_full,
  input  logic              init_busy,
  output logic              op_push,
  output pdf_pkg::op_t      op
);
  import pdf_pkg::*;

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_ENTRIES = 2'd1;
  localparam logic [1:0] PH_SKIP    = 2'd2;

  localparam logic [SLOT_W-1:0] SLOT_LIMIT = SLOT_W'(TABLE_ENTRIES);

  logic [1:0]        parse_phase, parse_phase_next;
  logic [SLOT_W-1:0] next_slot, next_slot_next;
  logic [CNT_W-1:0]  entries_left, entries_left_next;
  logic [CNT_W-1:0]  hdr_cnt;
  logic              accept;

  assign full    = q_full || init_busy;
  assign accept  = push && !full;
  assign op_push = accept;
  assign hdr_cnt = in_item.dir_word[WORD_W-1 -: CNT_W];

  always_comb begin
    parse_phase_next  = parse_phase;
    next_slot_next    = next_slot;
    entries_left_next = entries_left;
    op        = '0;
    op.kind   = OP_RESULT;
    op.status = STAT_IGNORED;
    op.word   = in_item.dir_word;
    unique case (in_item.cmd)
      CMD_WORD: begin
        if (parse_phase == PH_HEADER) begin
          next_slot_next    = {1'b0, in_item.dir_word[ID_W-1:0]};
          entries_left_next = hdr_cnt;
          // a zero count stops the atom: skip the rest of it
          parse_phase_next  = (hdr_cnt == '0) ? PH_SKIP : PH_ENTRIES;
          op.status         = STAT_HEADER;
        end else if (parse_phase == PH_ENTRIES) begin
          if (next_slot >= SLOT_LIMIT) begin
            op.status = STAT_RANGE;
          end else begin
            op.kind = OP_STORE;
            op.slot = next_slot[ID_W-1:0];
          end
          next_slot_next    = next_slot + 1'b1;
          entries_left_next = entries_left - 1'b1;
          if (entries_left_next == '0) begin
            parse_phase_next = PH_HEADER;
          end
        end
        if (in_item.last_word) begin
          parse_phase_next  = PH_HEADER;
          next_slot_next    = '0;
          entries_left_next = '0;
        end
      end
      CMD_LOOKUP: begin
        if ({1'b0, in_item.query_id} < SLOT_LIMIT) begin
          op.kind = OP_LOOKUP;
          op.slot = in_item.query_id;
        end else begin
          op.status = STAT_MISS;
        end
      end
      CMD_CLEAR: begin
        op.kind           = OP_CLEAR;
        parse_phase_next  = PH_HEADER;
        next_slot_next    = '0;
        entries_left_next = '0;
      end
      default: begin
        op.status = STAT_IGNORED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase  <= PH_HEADER;
      next_slot    <= '0;
      entries_left <= '0;
    end else if (accept) begin
      parse_phase  <= parse_phase_next;
      next_slot    <= next_slot_next;
      entries_left <= entries_left_next;
    end
  end

endmodule

// ===== rtl/core/pdf_queue.sv =====
// pdf_queue: short op queue between the parser front and the table back
// depends on pdf_pkg
module pdf_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr,
  input  pdf_pkg::op_t wr_op,
  output logic         q_full,
  input  logic         rd,
  output logic         q_empty,
  output pdf_pkg::op_t head
);
  import pdf_pkg::*;

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_QW = $clog2(Q_DEPTH + 1);

  op_t               slots [Q_DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_QW-1:0] count;
  logic              do_wr, do_rd;

  assign q_full  = (count == CNT_QW'(Q_DEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && !q_empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/pdf_back.sv =====
// pdf_back: offset table memory, store and lookup execution, clear sweeps, result register
// depends on pdf_pkg
module pdf_back #(
  parameter int TABLE_ENTRIES = pdf_pkg::DEF_TABLE_ENTRIES
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [pdf_pkg::LEN_W-1:0]   cfg_wdata,
  input  logic                        q_empty,
  input  pdf_pkg::op_t                head,
  output logic                        q_pop,
  output logic                        init_busy,
  output logic                        empty,
  input  logic                        pop,
  output pdf_pkg::out_item_t          out_item
);
  import pdf_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  localparam logic [1:0] ST_INIT  = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_CLEAR = 2'd3;

  logic [ENTRY_W-1:0] mem [TABLE_ENTRIES];
  logic [ENTRY_W-1:0] rd_data;
  logic [IDX_W-1:0]   rd_addr;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;

  logic [1:0]       state, state_next;
  logic [IDX_W-1:0] sweep_addr, sweep_addr_next;
  op_t              cur_op, cur_op_next;
  logic [LEN_W-1:0] stream_length;
  logic             out_valid, out_valid_next;
  out_item_t        out_reg, out_reg_next;
  logic             out_free;
  logic             offs_bad;

  assign init_busy = (state == ST_INIT);
  assign empty     = !out_valid;
  assign out_item  = out_reg;
  assign out_free  = !out_valid || pop;
  assign rd_addr   = head.slot[IDX_W-1:0];

  // offset + 8 must not run past the end of the stream
  assign offs_bad = ({1'b0, cur_op.word} + (WORD_W + 1)'(HEADER_BYTES))
                    > (WORD_W + 1)'(stream_length);

  always_comb begin
    state_next      = state;
    sweep_addr_next = sweep_addr;
    cur_op_next     = cur_op;
    out_valid_next  = out_valid && !pop;
    out_reg_next    = out_reg;
    q_pop           = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = sweep_addr;
    mem_wdata       = '0;
    unique case (state)
      ST_INIT: begin
        mem_we          = 1'b1;
        sweep_addr_next = sweep_addr + 1'b1;
        if (sweep_addr == LAST_IDX) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty && out_free) begin
          q_pop       = 1'b1;
          cur_op_next = head;
          unique case (head.kind)
            OP_RESULT: begin
              out_valid_next = 1'b1;
              out_reg_next   = '{status: head.status, found: 1'b0, offset_out: '0};
            end
            OP_STORE, OP_LOOKUP: begin
              state_next = ST_READ;
            end
            default: begin
              sweep_addr_next = '0;
              state_next      = ST_CLEAR;
            end
          endcase
        end
      end
      ST_READ: begin
        // table entry for cur_op was read on the previous edge
        out_valid_next = 1'b1;
        out_reg_next   = '0;
        state_next     = ST_IDLE;
        if (cur_op.kind == OP_LOOKUP) begin
          if (rd_data[ENTRY_W-1]) begin
            out_reg_next.status     = STAT_HIT;
            out_reg_next.found      = 1'b1;
            out_reg_next.offset_out = rd_data[OFFS_W-1:0];
          end else begin
            out_reg_next.status = STAT_MISS;
          end
        end else if (rd_data[ENTRY_W-1]) begin
          out_reg_next.status = STAT_SET;
        end else if (offs_bad) begin
          out_reg_next.status = STAT_BAD_OFFS;
        end else begin
          mem_we              = 1'b1;
          mem_waddr           = cur_op.slot[IDX_W-1:0];
          mem_wdata           = {1'b1, cur_op.word[OFFS_W-1:0]};
          out_reg_next.status = STAT_STORED;
        end
      end
      default: begin
        mem_we          = 1'b1;
        sweep_addr_next = sweep_addr + 1'b1;
        if (sweep_addr == LAST_IDX) begin
          out_valid_next = 1'b1;
          out_reg_next   = '{status: STAT_CLEARED, found: 1'b0, offset_out: '0};
          state_next     = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    cur_op  <= cur_op_next;
    out_reg <= out_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_INIT;
      sweep_addr    <= '0;
      out_valid     <= 1'b0;
      stream_length <= '0;
    end else begin
      state      <= state_next;
      sweep_addr <= sweep_addr_next;
      out_valid  <= out_valid_next;
      if (cfg_we) begin
        stream_length <= cfg_wdata;
      end
    end
  end

endmodule

// ===== rtl/core/persist_directory_fold_unit.sv =====
// persist_directory_fold_unit: top level of the persist directory fold unit
// depends on pdf_pkg, pdf_front, pdf_queue, pdf_back
//
// usage:
//   input side is a queue: drive in_item and push; the item is taken at an edge
//   with push high and full low. output side is a queue too: while empty is low
//   out_item holds the oldest result, and an edge with pop high takes it.
//   cfg_we with cfg_wdata writes stream_length (offset + 8 must fit in it);
//   write it only while the unit is idle.
// timing:
//   every item gives exactly one result, in order. the front classifies an item
//   in its accept cycle and hands it through a 4-entry op queue to the back.
//   the back's table memory sets the rate: header, ignored and out-of-range
//   items are answered straight from idle, stores and lookups pass a read state
//   (read, then decide and write), a clear command sweeps the table one entry
//   per cycle. the back takes a new op only once it is back in idle.
// reset and stall:
//   rst clears the parser, the queue and the result valid flag, then the whole
//   table is swept to zero with full held high. if pop stays low,
//   the back holds the result and the queue fills until full rises.
module persist_directory_fold_unit #(
  parameter int TABLE_ENTRIES = pdf_pkg::DEF_TABLE_ENTRIES
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  pdf_pkg::in_item_t         in_item,
  output logic                      empty,
  input  logic                      pop,
  output pdf_pkg::out_item_t        out_item,
  input  logic                      cfg_we,
  input  logic [pdf_pkg::LEN_W-1:0] cfg_wdata
);
  import pdf_pkg::*;

  logic q_full, q_empty, q_pop, op_push, init_busy;
  op_t  op, head;

  pdf_front #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .q_full    (q_full),
    .init_busy (init_busy),
    .op_push   (op_push),
    .op        (op)
  );

  pdf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (op_push),
    .wr_op   (op),
    .q_full  (q_full),
    .rd      (q_pop),
    .q_empty (q_empty),
    .head    (head)
  );

  pdf_back #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_empty   (q_empty),
    .head      (head),
    .q_pop     (q_pop),
    .init_busy (init_busy),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item)
  );

endmodule
